// ----- sv/ffsbt_pkg.sv -----
`timescale 1ns / 1ps

package ffsbt_pkg;

   localparam int SLOT_COUNT_DEFAULT = 128;

   // slots held by one cell of the occupancy chain
   localparam int CELL_SLOTS = 8;
   localparam int CELL_SEL_W = $clog2(CELL_SLOTS);

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_FREE   = 1'b1;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic               func;
      logic [15:0]        block_name;
      logic signed [31:0] first_value;
      logic signed [31:0] second_value;
      logic [7:0]         block_kind;
      logic [6:0]         slot_addr;
   } req_type;

   typedef struct packed {
      logic               status;
      logic [6:0]         slot;
      logic [31:0]        new_id;
      logic [15:0]        freed_name;
      logic signed [31:0] freed_first;
      logic signed [31:0] freed_second;
      logic [7:0]         freed_kind;
   } rsp_type;

   // stored payload of one slot
   typedef struct packed {
      logic [15:0]        name;
      logic signed [31:0] first;
      logic signed [31:0] second;
      logic [7:0]         kind;
   } entry_type;

   // top -> cell
   typedef struct packed {
      logic                  clr;
      logic [CELL_SEL_W-1:0] clr_sel;
   } cell_cmd_type;

   // cell -> top
   typedef struct packed {
      logic                  hit;
      logic [CELL_SEL_W-1:0] sel;
   } cell_claim_type;

endpackage

// ----- sv/ffsbt_cell.sv -----
`timescale 1ns / 1ps

module ffsbt_cell #(
   parameter int SLOT_COUNT = ffsbt_pkg::SLOT_COUNT_DEFAULT,
   parameter int CELL_ID    = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     tok_in,
   output logic                     tok_out,
   input  ffsbt_pkg::cell_cmd_type  cmd,
   output ffsbt_pkg::cell_claim_type claim
);

   localparam int BASE = CELL_ID * ffsbt_pkg::CELL_SLOTS;

   logic [ffsbt_pkg::CELL_SLOTS-1:0] occ_ff, occ_in;
   logic                             tok_ff, tok_in_r;
   logic [ffsbt_pkg::CELL_SLOTS-1:0] free_vec;
   logic                             any_free;
   logic [ffsbt_pkg::CELL_SEL_W-1:0] sel;

   // slots past the end of the table never look free
   always_comb begin
      for (int j = 0; j < ffsbt_pkg::CELL_SLOTS; j++) begin
         free_vec[j] = !occ_ff[j] && (BASE + j < SLOT_COUNT);
      end
   end

   assign any_free = |free_vec;

   always_comb begin
      sel = '0;
      for (int j = ffsbt_pkg::CELL_SLOTS - 1; j >= 0; j--) begin
         if (free_vec[j]) begin
            sel = ffsbt_pkg::CELL_SEL_W'(j);
         end
      end
   end

   assign claim.hit = tok_ff && any_free;
   assign claim.sel = sel;
   assign tok_out   = tok_ff && !any_free;
   assign tok_in_r  = tok_in;

   always_comb begin
      occ_in = occ_ff;
      if (claim.hit) begin
         occ_in[sel] = 1'b1;
      end
      if (cmd.clr) begin
         occ_in[cmd.clr_sel] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         tok_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         tok_ff <= tok_in_r;
      end
   end

endmodule

// ----- sv/ffsbt_store.sv -----
`timescale 1ns / 1ps

module ffsbt_store #(
   parameter int SLOT_COUNT = ffsbt_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
   input  ffsbt_pkg::entry_type        wr_data,
   input  logic                        rd_en,
   input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
   output ffsbt_pkg::entry_type        rd_data
);

   ffsbt_pkg::entry_type mem_ff [SLOT_COUNT];
   ffsbt_pkg::entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

// ----- sv/first_free_slot_block_table.sv -----
`timescale 1ns / 1ps

// First-fit slot table. One word is accepted when start is high and busy is
// low; every word gives exactly one result word, shown on rsp_data for one
// cycle with rsp_valid high, and the receiver cannot stall it. An insert
// sends a search token down a chain of cells, each covering 8 slots, one
// cell per cycle: it stays busy until the cell holding the lowest free slot
// claims it, or until the token has passed the last cell when the table is
// full, and its result shows in the first cycle busy is low again. A free
// spends its busy state on the payload memory read. A new word can be taken
// in the same cycle a result is shown. Reset clears the occupancy marks and
// id counter at once; no clearing pass follows.
module first_free_slot_block_table #(
   parameter int SLOT_COUNT = ffsbt_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  ffsbt_pkg::req_type req_data,
   output logic               rsp_valid,
   output ffsbt_pkg::rsp_type rsp_data
);

   localparam int SLOT_W = $clog2(SLOT_COUNT);
   localparam int ADDR_W = (SLOT_W > 7) ? SLOT_W : 7;
   localparam int NCELL  = (SLOT_COUNT + ffsbt_pkg::CELL_SLOTS - 1) / ffsbt_pkg::CELL_SLOTS;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;

   logic [1:0]         state_ff, state_in;
   ffsbt_pkg::req_type req_ff, req_in;
   logic [31:0]        id_ff, id_in;
   logic [6:0]         addr_ff, addr_in;
   logic               inrange_ff, inrange_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ffsbt_pkg::rsp_type rsp_ff, rsp_in;

   logic                accept, launch, free_go, inrange, any_hit, full;
   logic [ADDR_W-1:0]   addr_ext;
   logic [SLOT_W-1:0]   addr_idx, clr_cell, hit_slot;
   logic [ffsbt_pkg::CELL_SEL_W-1:0] clr_sel;
   logic [NCELL:0]      tok;
   logic [NCELL-1:0]    hits;
   ffsbt_pkg::cell_cmd_type   cmd   [NCELL];
   ffsbt_pkg::cell_claim_type claim [NCELL];
   ffsbt_pkg::entry_type      wr_data, rd_data;

   assign accept   = start && !busy;
   assign busy     = (state_ff != ST_IDLE);
   assign inrange  = (32'(req_data.slot_addr) < SLOT_COUNT);
   assign launch   = accept && (req_data.func == ffsbt_pkg::FUNC_INSERT);
   assign free_go  = accept && (req_data.func == ffsbt_pkg::FUNC_FREE) && inrange;
   assign addr_ext = ADDR_W'(req_data.slot_addr);
   assign addr_idx = addr_ext[SLOT_W-1:0];
   assign clr_cell = addr_idx >> ffsbt_pkg::CELL_SEL_W;
   assign clr_sel  = ffsbt_pkg::CELL_SEL_W'(addr_idx);

   assign tok[0] = launch;
   assign full   = tok[NCELL];

   for (genvar c = 0; c < NCELL; c++) begin : g_cell
      assign cmd[c].clr     = free_go && (int'(clr_cell) == c);
      assign cmd[c].clr_sel = clr_sel;
      assign hits[c]        = claim[c].hit;

      ffsbt_cell #(
         .SLOT_COUNT(SLOT_COUNT),
         .CELL_ID   (c)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .tok_in (tok[c]),
         .tok_out(tok[c+1]),
         .cmd    (cmd[c]),
         .claim  (claim[c])
      );
   end

   assign any_hit = |hits;

   // at most one cell holds the token, so OR the claims together
   always_comb begin
      hit_slot = '0;
      for (int c = 0; c < NCELL; c++) begin
         if (claim[c].hit) begin
            hit_slot = hit_slot
               | SLOT_W'(c * ffsbt_pkg::CELL_SLOTS + int'(claim[c].sel));
         end
      end
   end

   assign wr_data.name   = req_ff.block_name;
   assign wr_data.first  = req_ff.first_value;
   assign wr_data.second = req_ff.second_value;
   assign wr_data.kind   = req_ff.block_kind;

   ffsbt_store #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_store (
      .clock  (clock),
      .wr_en  ((state_ff == ST_SCAN) && any_hit),
      .wr_addr(hit_slot),
      .wr_data(wr_data),
      .rd_en  (free_go),
      .rd_addr(addr_idx),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      id_in        = id_ff;
      addr_in      = addr_ff;
      inrange_in   = inrange_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in     = req_data;
               addr_in    = req_data.slot_addr;
               inrange_in = inrange;
               state_in   = (req_data.func == ffsbt_pkg::FUNC_INSERT) ? ST_SCAN : ST_READ;
            end
         end
         ST_SCAN: begin
            if (any_hit) begin
               id_in               = id_ff + 32'd1;
               rsp_valid_in        = 1'b1;
               rsp_in              = '0;
               rsp_in.status       = ffsbt_pkg::STATUS_DONE;
               rsp_in.slot         = 7'(hit_slot);
               rsp_in.new_id       = id_ff + 32'd1;
               state_in            = ST_IDLE;
            end else if (full) begin
               rsp_valid_in        = 1'b1;
               rsp_in              = '0;
               rsp_in.status       = ffsbt_pkg::STATUS_FULL;
               state_in            = ST_IDLE;
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            rsp_in.status = ffsbt_pkg::STATUS_DONE;
            rsp_in.slot   = addr_ff;
            if (inrange_ff) begin
               rsp_in.freed_name   = rd_data.name;
               rsp_in.freed_first  = rd_data.first;
               rsp_in.freed_second = rd_data.second;
               rsp_in.freed_kind   = rd_data.kind;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         id_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         id_ff        <= id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      addr_ff    <= addr_in;
      inrange_ff <= inrange_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- sv/ffsbt_checker.sv -----
`timescale 1ns / 1ps

module ffsbt_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input ffsbt_pkg::rsp_type rsp_data
);

   // every accepted word raises busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   // the result shows as busy drops
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_no_double: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in a row");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ffsbt_pkg::STATUS_FULL)
         |-> (rsp_data.new_id == 32'd0) && (rsp_data.slot == 7'd0))
      else $error("refused insert carries a slot or id");

endmodule

bind first_free_slot_block_table ffsbt_checker u_ffsbt_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .rsp_valid(rsp_valid),
   .rsp_data (rsp_data)
);

// ----- dv/tb_first_free_slot_block_table.sv -----
`timescale 1ns / 1ps

module tb_first_free_slot_block_table;
   import ffsbt_pkg::*;

   localparam int SLOTS = SLOT_COUNT_DEFAULT;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   first_free_slot_block_table dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // shadow copy of the slot table
   logic        slot_used    [SLOTS];
   logic        slot_written [SLOTS];
   entry_type   slot_entry   [SLOTS];
   logic [31:0] id_count;
   int          used_count;
   int          written_count;

   rsp_type expected_rsp [$];
   int      error_count = 0;
   int      idle_pct = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic rsp_type predict_table_op(input req_type w);
      rsp_type r;
      int      pick;
      r = '0;
      pick = -1;
      if (w.func == FUNC_INSERT) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (!slot_used[i]) begin
               pick = i;
               break;
            end
         end
         if (pick < 0) begin
            r.status = STATUS_FULL;
         end else begin
            id_count = id_count + 32'd1;
            slot_used[pick] = 1'b1;
            used_count++;
            if (!slot_written[pick]) written_count++;
            slot_written[pick] = 1'b1;
            slot_entry[pick] = '{w.block_name, w.first_value, w.second_value, w.block_kind};
            r.status = STATUS_DONE;
            r.slot   = 7'(pick);
            r.new_id = id_count;
         end
      end else begin
         r.status = STATUS_DONE;
         r.slot   = w.slot_addr;
         if (int'(w.slot_addr) < SLOTS) begin
            if (slot_used[w.slot_addr]) used_count--;
            slot_used[w.slot_addr] = 1'b0;
            r.freed_name   = slot_entry[w.slot_addr].name;
            r.freed_first  = slot_entry[w.slot_addr].first;
            r.freed_second = slot_entry[w.slot_addr].second;
            r.freed_kind   = slot_entry[w.slot_addr].kind;
         end
      end
      return r;
   endfunction

   function automatic req_type random_word(input logic f, input logic [6:0] addr);
      req_type w;
      w.func         = f;
      w.block_name   = 16'($urandom);
      w.first_value  = $urandom;
      w.second_value = $urandom;
      w.block_kind   = 8'($urandom);
      w.slot_addr    = addr;
      return w;
   endfunction

   // mostly an occupied slot, otherwise any slot written before
   function automatic logic [6:0] choose_release_slot();
      int pool [$];
      bit want_used;
      want_used = (used_count != 0) && ($urandom_range(99) < 85);
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_written[i] && (!want_used || slot_used[i])) pool.push_back(i);
      end
      return 7'(pool[$urandom_range(pool.size() - 1)]);
   endfunction

   // start stays high across back-to-back words
   task automatic send_word(input req_type w);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      expected_rsp.push_back(predict_table_op(w));
   endtask

   task automatic send_insert();
      send_word(random_word(FUNC_INSERT, 7'($urandom)));
   endtask

   task automatic send_release(input logic [6:0] addr);
      send_word(random_word(FUNC_FREE, addr));
   endtask

   task automatic test_directed_extremes();
      req_type w;
      w = '0;
      w.func = FUNC_INSERT;
      send_word(w);
      w.block_name   = 16'hFFFF;
      w.first_value  = 32'sh7FFF_FFFF;
      w.second_value = 32'sh8000_0000;
      w.block_kind   = 8'hFF;
      w.slot_addr    = 7'h7F;
      send_word(w);
      w.block_name   = 16'h0000;
      w.first_value  = 32'sh8000_0000;
      w.second_value = 32'sh7FFF_FFFF;
      w.block_kind   = 8'h00;
      send_word(w);
      w.first_value  = -32'sd1;
      w.second_value = 32'sd0;
      send_word(w);
      send_release(7'd1);
      // releasing an already free slot still returns its payload
      send_release(7'd1);
      send_insert();
      send_release(7'd0);
      send_release(7'd2);
      send_insert();
      send_insert();
      // walk across the first cell boundary
      repeat (6) send_insert();
      send_release(7'd8);
      send_insert();
      send_release(7'd3);
      send_release(7'd9);
      send_insert();
   endtask

   task automatic test_table_full();
      while (used_count < SLOTS) send_insert();
      send_insert();
      send_insert();
      send_release(7'd127);
      send_insert();
      send_release(7'($urandom_range(SLOTS - 1)));
      send_insert();
      send_insert();
      for (int s = SLOTS - 1; s >= 0; s--) send_release(7'(s));
      send_release(7'd5);
   endtask

   task automatic test_random_mix(input int n, input int idle);
      int insert_pct;
      idle_pct = idle;
      insert_pct = 50;
      for (int k = 0; k < n; k++) begin
         if (k % 64 == 0) insert_pct = 20 + 25 * $urandom_range(3);
         if (written_count == 0 || $urandom_range(99) < insert_pct) send_insert();
         else send_release(choose_release_slot());
      end
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_rsp.size() == 0) begin
            report_error("result word with no request pending");
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.status !== want.status)
               report_error($sformatf("status %0h, expected %0h", rsp_data.status, want.status));
            if (rsp_data.slot !== want.slot)
               report_error($sformatf("slot %0d, expected %0d", rsp_data.slot, want.slot));
            if (rsp_data.new_id !== want.new_id)
               report_error($sformatf("new_id %0h, expected %0h", rsp_data.new_id, want.new_id));
            if (rsp_data.freed_name !== want.freed_name)
               report_error($sformatf("freed_name %0h, expected %0h",
                                      rsp_data.freed_name, want.freed_name));
            if (rsp_data.freed_first !== want.freed_first)
               report_error($sformatf("freed_first %0h, expected %0h",
                                      rsp_data.freed_first, want.freed_first));
            if (rsp_data.freed_second !== want.freed_second)
               report_error($sformatf("freed_second %0h, expected %0h",
                                      rsp_data.freed_second, want.freed_second));
            if (rsp_data.freed_kind !== want.freed_kind)
               report_error($sformatf("freed_kind %0h, expected %0h",
                                      rsp_data.freed_kind, want.freed_kind));
         end
      end
   end

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         slot_used[i]    = 1'b0;
         slot_written[i] = 1'b0;
         slot_entry[i]   = '0;
      end
      id_count      = '0;
      used_count    = 0;
      written_count = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_pct = 34;
      test_directed_extremes();
      test_table_full();
      test_random_mix(460, 34);
      test_random_mix(460, 67);
      test_random_mix(460, 0);
      start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      // leave time for the longest insert search, down the whole cell chain
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/ffsbt_pkg.sv
sv/ffsbt_cell.sv
sv/ffsbt_store.sv
sv/first_free_slot_block_table.sv
sv/ffsbt_checker.sv
dv/tb_first_free_slot_block_table.sv
